// ----- design/flcv_pkg.sv -----
// Shared widths and limits for the full linear convolution core.
`default_nettype none
package flcv_pkg;
	localparam int MAX_TAPS = 32;
	localparam int TAP_W    = $clog2(MAX_TAPS);
	localparam int CNT_W    = $clog2(MAX_TAPS + 1);
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int SUM_W    = 37;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_COEF   = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [TAP_W-1:0]           tap_idx_t;
	typedef logic [CNT_W-1:0]           tap_cnt_t;
endpackage
`default_nettype wire

// ----- design/flcv_item_if.sv -----
// Input channel: samples and coefficient writes.
`default_nettype none
interface flcv_item_if import flcv_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     mode;
	tap_idx_t tap_index;
	sample_t  value;
	logic     last_sample;

	modport source (output valid, input ready, output mode, output tap_index,
		output value, output last_sample);
	modport sink (input valid, output ready, input mode, input tap_index,
		input value, input last_sample);
endinterface
`default_nettype wire

// ----- design/flcv_result_if.sv -----
// Output channel: convolution results.
`default_nettype none
interface flcv_result_if import flcv_pkg::*; ();
	logic valid;
	logic ready;
	sum_t sum;
	logic last_output;

	modport source (output valid, input ready, output sum, output last_output);
	modport sink (input valid, output ready, input sum, input last_output);
endinterface
`default_nettype wire

// ----- design/full_linear_convolution_core.sv -----
// Full linear convolution core: direct-form FIR with a rotating delay line.
//
// A coefficient write (mode 1) produces no output. A signal sample (mode 0)
// is shifted into a 32-entry delay line ring, which then rotates once
// through a single 16x16 multiply-accumulate, one tap per cycle; the
// coefficient store is read at the same tap index. Each output therefore
// passes through a shift, a full ring rotation, the pipeline drain and the
// hand-off of the sum to the output register, independent of tap_count. A
// sample marked last is followed by taps_eff-1 tail outputs; the hand-off
// before each one also shifts in a zero, and after the last output the
// delay line is zeroed. The input channel is ready only between items; a
// finished result waits in the output register while the next item is
// taken. tap_count 0 acts as 1, values above 32 act as 32.
`default_nettype none
module full_linear_convolution_core import flcv_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	flcv_item_if.sink          item,
	flcv_result_if.source      result,
	input  wire logic          cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	tap_cnt_t   tap_count_q;
	tap_cnt_t   taps_eff;
	sample_t    ring_q [MAX_TAPS];
	sample_t    coef_mem [MAX_TAPS];
	tap_idx_t   cnt_q;
	tap_idx_t   tail_q;
	logic       last_q;
	sample_t    coef_s1;
	sample_t    samp_s1;
	logic       v_s1;
	prod_t      prod_s2;
	logic       v_s2;
	sum_t       acc_q;
	logic       out_valid_q;
	sum_t       out_sum_q;
	logic       out_last_q;
	logic       item_xfer;
	logic       sample_xfer;
	logic       coef_we;
	logic       emit_go;
	logic       tail_go;

	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = CNT_W'(1);
		end else if (tap_count_q > CNT_W'(MAX_TAPS)) begin
			taps_eff = CNT_W'(MAX_TAPS);
		end else begin
			taps_eff = tap_count_q;
		end
	end

	assign item.ready   = (state_q == ST_IDLE);
	assign item_xfer    = item.valid && item.ready;
	assign sample_xfer  = item_xfer && (item.mode == MODE_SAMPLE);
	assign coef_we      = item_xfer && (item.mode == MODE_COEF);
	assign emit_go      = (state_q == ST_EMIT) && (!out_valid_q || result.ready);
	assign tail_go      = emit_go && (tail_q != '0);

	assign result.valid       = out_valid_q;
	assign result.sum         = out_sum_q;
	assign result.last_output = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			tail_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sample_xfer) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
						last_q  <= item.last_sample;
						tail_q  <= item.last_sample ? TAP_W'(taps_eff - CNT_W'(1)) : '0;
					end
				end
				ST_MAC: begin
					cnt_q <= cnt_q + TAP_W'(1);
					if (cnt_q == TAP_W'(MAX_TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cnt_q <= cnt_q + TAP_W'(1);
					if (cnt_q == TAP_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (tail_go) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
						tail_q  <= tail_q - TAP_W'(1);
					end else if (emit_go) begin
						state_q <= ST_IDLE;
						last_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// shift in, rotate, or clear the delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				ring_q[i] <= '0;
			end
		end else if (sample_xfer || tail_go) begin
			ring_q[0] <= sample_xfer ? item.value : '0;
			for (int i = 1; i < MAX_TAPS; i++) begin
				ring_q[i] <= ring_q[i-1];
			end
		end else if (state_q == ST_MAC) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				ring_q[i] <= ring_q[(i + 1) % MAX_TAPS];
			end
		end else if (emit_go && last_q) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				ring_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[item.tap_index] <= item.value;
		end
		coef_s1 <= coef_mem[cnt_q];
		samp_s1 <= ring_q[0];
		prod_s2 <= coef_s1 * samp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= (state_q == ST_MAC) && ({1'b0, cnt_q} < taps_eff);
			v_s2 <= v_s1;
			if (sample_xfer || tail_go) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_sum_q  <= acc_q;
			out_last_q <= last_q && (tail_q == '0);
		end
	end
endmodule
`default_nettype wire

// ----- design/flcv_checker.sv -----
// Port-level checks for the full linear convolution core, with its bind.
`default_nettype none
module flcv_checker import flcv_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_ready,
	input wire logic item_mode,
	input wire logic result_valid,
	input wire logic result_ready
);
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transfer");

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !item_mode |=> !item_ready)
		else $error("input ready right after a sample transfer");

	a_coef_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_mode |=> item_ready)
		else $error("coefficient write stalled the input");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !item_mode |=> !$rose(result_valid))
		else $error("result appeared right after a sample transfer");
endmodule

bind full_linear_convolution_core flcv_checker u_flcv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_mode    (item.mode),
	.result_valid (result.valid),
	.result_ready (result.ready)
);
`default_nettype wire
